// File: hdl/smf_pkg.sv
package smf_pkg;

  localparam int unsigned DEF_MAX_WIDTH     = 128;
  localparam int unsigned DEF_MAX_HEIGHT    = 128;
  localparam int unsigned DEF_MAX_CHANNELS  = 4;
  localparam int unsigned DEF_MAX_WINDOW_XY = 5;
  localparam int unsigned DEF_MAX_FRAMES    = 5;
  localparam int unsigned DEF_SAMPLE_BITS   = 16;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned COORD_BITS    = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_CHANNEL_COUNT  = 3'd2,
    REG_WINDOW_X       = 3'd3,
    REG_WINDOW_Y       = 3'd4,
    REG_WINDOW_Z       = 3'd5,
    REG_COMPARE_SIGNED = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // effective (clamped) settings
  typedef struct packed {
    logic [7:0] fw;
    logic [7:0] fh;
    logic [2:0] cc;
    logic [2:0] wx;
    logic [2:0] wy;
    logic [2:0] wz;
    logic       sgn;
  } cfg_t;

  typedef struct packed {
    logic        query;
    logic        store_en;
    logic        frame_end;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [1:0]  ch;
    logic [15:0] sample;
  } cmd_t;

  function automatic logic [7:0] clamp_dim(logic [7:0] v, int unsigned maxv);
    logic [7:0] r;
    if (v == 8'd0) r = 8'd1;
    else if (32'(v) > maxv) r = 8'(maxv);
    else r = v;
    return r;
  endfunction

  function automatic logic [2:0] clamp_win(logic [2:0] v, int unsigned maxv);
    logic [2:0] r;
    if (v == 3'd0) r = 3'd1;
    else if (32'(v) > maxv) r = 3'(maxv);
    else r = v;
    if (!r[0]) r = r - 3'd1;
    return r;
  endfunction

endpackage

// File: hdl/smf_fifo.sv
module smf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// File: hdl/smf_front.sv
module smf_front #(
  parameter int unsigned MAX_WIDTH     = smf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = smf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS  = smf_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_WINDOW_XY = smf_pkg::DEF_MAX_WINDOW_XY,
  parameter int unsigned MAX_FRAMES    = smf_pkg::DEF_MAX_FRAMES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [smf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [smf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_push,
  input  logic                                 in_op,
  input  logic [6:0]                           in_pos_x,
  input  logic [6:0]                           in_pos_y,
  input  logic [1:0]                           in_chan,
  input  logic [15:0]                          in_sample,
  input  logic                                 in_frame_end,
  input  logic                                 q_full,
  output logic                                 q_push,
  output smf_pkg::cmd_t                        q_cmd,
  output smf_pkg::cfg_t                        cfg
);
  import smf_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:    cfg_nxt.fw  = clamp_dim(cfg_data, MAX_WIDTH);
        REG_FRAME_HEIGHT:   cfg_nxt.fh  = clamp_dim(cfg_data, MAX_HEIGHT);
        REG_CHANNEL_COUNT:  cfg_nxt.cc  = 3'(clamp_dim({5'd0, cfg_data[2:0]}, MAX_CHANNELS));
        REG_WINDOW_X:       cfg_nxt.wx  = clamp_win(cfg_data[2:0], MAX_WINDOW_XY);
        REG_WINDOW_Y:       cfg_nxt.wy  = clamp_win(cfg_data[2:0], MAX_WINDOW_XY);
        REG_WINDOW_Z:       cfg_nxt.wz  = clamp_win(cfg_data[2:0], MAX_FRAMES);
        REG_COMPARE_SIGNED: cfg_nxt.sgn = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fw  <= clamp_dim(8'd128, MAX_WIDTH);
      cfg_r.fh  <= clamp_dim(8'd128, MAX_HEIGHT);
      cfg_r.cc  <= 3'(clamp_dim(8'd1, MAX_CHANNELS));
      cfg_r.wx  <= clamp_win(3'd3, MAX_WINDOW_XY);
      cfg_r.wy  <= clamp_win(3'd3, MAX_WINDOW_XY);
      cfg_r.wz  <= clamp_win(3'd3, MAX_FRAMES);
      cfg_r.sgn <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify: writes outside the frame store nothing, query channel saturates
  always_comb begin
    q_cmd.query     = (op_t'(in_op) == OP_QUERY);
    q_cmd.store_en  = ({1'b0, in_pos_x} < cfg_r.fw) && ({1'b0, in_pos_y} < cfg_r.fh)
                      && ({1'b0, in_chan} < cfg_r.cc);
    q_cmd.frame_end = in_frame_end;
    q_cmd.x         = in_pos_x;
    q_cmd.y         = in_pos_y;
    q_cmd.ch        = in_chan;
    if (q_cmd.query && ({1'b0, in_chan} >= cfg_r.cc)) q_cmd.ch = 2'(cfg_r.cc - 3'd1);
    q_cmd.sample    = in_sample;
  end

  assign q_push = in_push && !q_full;

endmodule

// File: hdl/smf_back.sv
module smf_back #(
  parameter int unsigned MAX_WIDTH     = smf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = smf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS  = smf_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_WINDOW_XY = smf_pkg::DEF_MAX_WINDOW_XY,
  parameter int unsigned MAX_FRAMES    = smf_pkg::DEF_MAX_FRAMES,
  parameter int unsigned SAMPLE_BITS   = smf_pkg::DEF_SAMPLE_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  smf_pkg::cfg_t  cfg,
  input  smf_pkg::cmd_t  cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output logic [15:0]    res_median
);
  import smf_pkg::*;

  localparam int unsigned SLOT    = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned DEPTH   = MAX_FRAMES * SLOT;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WIN_MAX = MAX_WINDOW_XY * MAX_WINDOW_XY * MAX_FRAMES;
  localparam int unsigned IW      = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_GATHER = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] mem_r [DEPTH];

  logic [2:0]  fill_r, fill_nxt;
  logic [2:0]  z_r, z_nxt, k_r, k_nxt, j_r, j_nxt;
  logic signed [COORD_BITS-1:0] x0_r, y0_r;
  logic [1:0]  ch_r;
  logic [IW-1:0] mid_r;
  logic [SAMPLE_BITS-1:0] flip;

  logic        a_vld_r;
  logic [2:0]  a_z_r;
  logic [7:0]  a_row_r, a_col_r;
  logic        b_vld_r;
  logic [AW-1:0] b_addr_r;
  logic        c_vld_r;
  logic [SAMPLE_BITS-1:0] c_data_r;

  logic [SAMPLE_BITS-1:0] cell_r [WIN_MAX];
  logic [WIN_MAX-1:0]     cvld_r;
  logic [SAMPLE_BITS-1:0] cell_nxt [WIN_MAX];
  logic [WIN_MAX-1:0]     cvld_nxt;
  logic [WIN_MAX-1:0]     gt;
  logic [SAMPLE_BITS-1:0] ins_v;

  logic signed [COORD_BITS-1:0] ys, xs;
  logic [7:0]  row, col;
  logic        issue, last, start_q, do_write;
  logic [AW-1:0] waddr;
  logic [8:0]  wsize;

  function automatic logic [AW-1:0] addr_of(logic [2:0] z, logic [7:0] r, logic [7:0] c,
                                            logic [1:0] h);
    return AW'((AW'(z) * AW'(SLOT)) + (AW'(r) * AW'(MAX_WIDTH) + AW'(c)) * AW'(MAX_CHANNELS)
               + AW'(h));
  endfunction

  assign flip = cfg.sgn ? SIGN : '0;

  assign start_q  = (state_r == S_IDLE) && !cmd_empty && cmd.query;
  assign do_write = (state_r == S_IDLE) && !cmd_empty && !cmd.query;
  assign cmd_pop  = start_q || do_write;
  assign waddr    = addr_of(fill_r, {1'b0, cmd.y}, {1'b0, cmd.x}, cmd.ch);
  assign wsize    = 9'(cfg.wx) * 9'(cfg.wy) * 9'(cfg.wz);

  // neighbour coordinates, clamped into the frame
  assign ys = y0_r + $signed({{(COORD_BITS-3){1'b0}}, k_r});
  assign xs = x0_r + $signed({{(COORD_BITS-3){1'b0}}, j_r});
  always_comb begin
    if (ys < 0) row = 8'd0;
    else if (ys >= $signed({{(COORD_BITS-8){1'b0}}, cfg.fh})) row = cfg.fh - 8'd1;
    else row = 8'(ys);
    if (xs < 0) col = 8'd0;
    else if (xs >= $signed({{(COORD_BITS-8){1'b0}}, cfg.fw})) col = cfg.fw - 8'd1;
    else col = 8'(xs);
  end

  assign issue = (state_r == S_GATHER);
  assign last  = (j_r == cfg.wx - 3'd1) && (k_r == cfg.wy - 3'd1) && (z_r == cfg.wz - 3'd1);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    z_nxt = z_r;
    k_nxt = k_r;
    j_nxt = j_r;
    res_push = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (do_write && cmd.frame_end)
          fill_nxt = (fill_r + 3'd1 >= cfg.wz) ? 3'd0 : fill_r + 3'd1;
        if (start_q) begin
          z_nxt = '0;
          k_nxt = '0;
          j_nxt = '0;
          state_nxt = S_GATHER;
        end
      end
      S_GATHER: begin
        if (j_r == cfg.wx - 3'd1) begin
          j_nxt = '0;
          if (k_r == cfg.wy - 3'd1) begin
            k_nxt = '0;
            z_nxt = z_r + 3'd1;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
        if (last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!a_vld_r && !b_vld_r && !c_vld_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // ring shortened by a window_z write
    if (fill_nxt >= cfg.wz) fill_nxt = 3'd0;
  end

  assign res_median = 16'(cell_r[mid_r] ^ flip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      cvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      a_vld_r <= issue;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      cvld_r  <= start_q ? '0 : cvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r <= z_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    if (start_q) begin
      x0_r  <= $signed({{(COORD_BITS-7){1'b0}}, cmd.x})
               - $signed({{(COORD_BITS-2){1'b0}}, cfg.wx[2:1]});
      y0_r  <= $signed({{(COORD_BITS-7){1'b0}}, cmd.y})
               - $signed({{(COORD_BITS-2){1'b0}}, cfg.wy[2:1]});
      ch_r  <= cmd.ch;
      mid_r <= IW'(wsize >> 1);
    end
    a_z_r    <= z_r;
    a_row_r  <= row;
    a_col_r  <= col;
    b_addr_r <= addr_of(a_z_r, a_row_r, a_col_r, ch_r);
    for (int i = 0; i < WIN_MAX; i++) cell_r[i] <= cell_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (do_write && cmd.store_en) mem_r[waddr] <= SAMPLE_BITS'(cmd.sample);
    c_data_r <= mem_r[b_addr_r];
  end

  // sorted insertion row, ascending, one sample a cycle
  assign ins_v = c_data_r ^ flip;
  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) gt[i] = !cvld_r[i] || (cell_r[i] > ins_v);
    for (int i = 0; i < WIN_MAX; i++) begin
      cell_nxt[i] = cell_r[i];
      cvld_nxt[i] = cvld_r[i];
      if (c_vld_r && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
          cvld_nxt[i] = cvld_r[(i > 0) ? i - 1 : 0];
        end else begin
          cell_nxt[i] = ins_v;
          cvld_nxt[i] = 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/spatiotemporal_median_filter_core.sv
// channel  beat                                       handshake
// cfg      cfg_index, cfg_data                        cfg_wr_en
// in       op, pos_x, pos_y, chan, sample, frame_end  in_push / in_full
// out      median                                     out_pop / out_empty
//
// Write beat: stored by the back end straight from idle. Query beat: its
// wx*wy*wz window is read through the frame store's single read port.
// Front and back are parted by a 2-entry queue; results sit in a 2-entry queue.
// Reset clears control only; frame store is undefined until written.
// A full result queue stalls the back end at the end of a query.
module spatiotemporal_median_filter_core #(
  parameter int unsigned MAX_WIDTH     = smf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = smf_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS  = smf_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_WINDOW_XY = smf_pkg::DEF_MAX_WINDOW_XY,
  parameter int unsigned MAX_FRAMES    = smf_pkg::DEF_MAX_FRAMES,
  parameter int unsigned SAMPLE_BITS   = smf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [smf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [smf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic [6:0]                        in_pos_x,
  input  logic [6:0]                        in_pos_y,
  input  logic [1:0]                        in_chan,
  input  logic [15:0]                       in_sample,
  input  logic                              in_frame_end,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [15:0]                       out_median
);
  import smf_pkg::*;

  cfg_t        cfg;
  cmd_t        q_cmd, head;
  logic [$bits(cmd_t)-1:0] head_raw;
  logic        q_push, q_full, cmd_empty, cmd_pop;
  logic        res_push, res_full;
  logic [15:0] res_median;

  assign in_full = q_full;
  assign head    = cmd_t'(head_raw);

  smf_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW_XY(MAX_WINDOW_XY), .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_op(in_op), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_chan(in_chan), .in_sample(in_sample), .in_frame_end(in_frame_end),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd), .cfg(cfg)
  );

  smf_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_cmd), .full(q_full),
    .pop(cmd_pop), .rdata(head_raw), .empty(cmd_empty)
  );

  smf_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW_XY(MAX_WINDOW_XY), .MAX_FRAMES(MAX_FRAMES), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .cmd(head), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res_median(res_median)
  );

  smf_fifo #(.WIDTH(16), .DEPTH(2)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .wdata(res_median), .full(res_full),
    .pop(out_pop), .rdata(out_median), .empty(out_empty)
  );

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  a_cmd_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty) else $error("command taken from empty queue");

  a_res_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !res_push) else $error("results on consecutive cycles");

endmodule

// File: verif/tb_spatiotemporal_median_filter_core.sv
module tb_spatiotemporal_median_filter_core;
  import smf_pkg::*;

  localparam int unsigned SLOT_WORDS = 128 * 128 * 4;
  localparam int unsigned MEM_WORDS  = 5 * SLOT_WORDS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = 1'b0;
  logic [6:0]  in_pos_x = '0;
  logic [6:0]  in_pos_y = '0;
  logic [1:0]  in_chan = '0;
  logic [15:0] in_sample = '0;
  logic        in_frame_end = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_median;

  spatiotemporal_median_filter_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_chan(in_chan),
    .in_sample(in_sample), .in_frame_end(in_frame_end),
    .out_empty(out_empty), .out_pop(out_pop), .out_median(out_median)
  );

  typedef struct {
    op_t         op;
    int          x;
    int          y;
    int          c;
    logic [15:0] smp;
    bit          fe;
    bit          has_exp;
    logic [15:0] exp_med;
  } beat_t;

  // shadow of the block
  logic [15:0] pix_mem [0:MEM_WORDS-1];
  int eff_w, eff_h, eff_c, win_x, win_y, win_z, ring_slot;
  bit cmp_sgn;

  logic [15:0] median_q[$];
  int errs = 0;
  int n_results = 0;
  bit calm = 1'b0;
  bit held_off = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 2000000);
    $display("spatiotemporal_median_filter_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_results);
    errs++;
  endtask

  function automatic int sat_dim(int v, int mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic int sat_win(int v, int mx);
    int w;
    w = sat_dim(v, mx);
    if (w % 2 == 0) w = w - 1;
    return w;
  endfunction

  function automatic int pix_addr(int s, int x, int y, int c);
    return s * SLOT_WORDS + (y * 128 + x) * 4 + c;
  endfunction

  function automatic int edge_clamp(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  function automatic logic [15:0] window_median(int px, int py, int pc);
    logic [15:0] keys[$];
    logic [15:0] flip;
    int c, row, col;
    flip = cmp_sgn ? 16'h8000 : 16'h0000;
    c = (pc >= eff_c) ? eff_c - 1 : pc;
    for (int z = 0; z < win_z; z++)
      for (int k = 0; k < win_y; k++) begin
        row = edge_clamp(py - win_y / 2 + k, eff_h);
        for (int j = 0; j < win_x; j++) begin
          col = edge_clamp(px - win_x / 2 + j, eff_w);
          keys.push_back(pix_mem[pix_addr(z, col, row, c)] ^ flip);
        end
      end
    keys.sort();
    return keys[keys.size() / 2] ^ flip;
  endfunction

  task automatic write_reg(cfg_reg_t r, int raw);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= 8'(raw);
    @(posedge clk);
    case (r)
      REG_FRAME_WIDTH:    eff_w = sat_dim(raw & 8'hFF, 128);
      REG_FRAME_HEIGHT:   eff_h = sat_dim(raw & 8'hFF, 128);
      REG_CHANNEL_COUNT:  eff_c = sat_dim(raw & 7, 4);
      REG_WINDOW_X:       win_x = sat_win(raw & 7, 5);
      REG_WINDOW_Y:       win_y = sat_win(raw & 7, 5);
      REG_WINDOW_Z: begin
        win_z = sat_win(raw & 7, 5);
        if (ring_slot >= win_z) ring_slot = 0;
      end
      REG_COMPARE_SIGNED: cmp_sgn = raw & 1;
      default: ;
    endcase
  endtask

  task automatic set_regs(int fw, int fh, int cc, int wx, int wy, int wz, int sg);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_CHANNEL_COUNT, cc);
    write_reg(REG_WINDOW_X, wx);
    write_reg(REG_WINDOW_Y, wy);
    write_reg(REG_WINDOW_Z, wz);
    write_reg(REG_COMPARE_SIGNED, sg);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_beat(beat_t b);
    in_push      <= 1'b1;
    in_op        <= b.op;
    in_pos_x     <= 7'(b.x);
    in_pos_y     <= 7'(b.y);
    in_chan      <= 2'(b.c);
    in_sample    <= b.smp;
    in_frame_end <= b.fe;
    do @(posedge clk); while (in_full);
    if (b.op == OP_QUERY) begin
      median_q.push_back(b.has_exp ? b.exp_med : window_median(b.x, b.y, b.c));
    end else begin
      if (b.x < eff_w && b.y < eff_h && b.c < eff_c)
        pix_mem[pix_addr(ring_slot, b.x, b.y, b.c)] = b.smp;
      if (b.fe) begin
        ring_slot++;
        if (ring_slot >= win_z) ring_slot = 0;
      end
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // every entry of every ring slot in use gets written once
  task automatic fill_ring();
    beat_t b;
    for (int s = 0; s < win_z; s++)
      for (int y = 0; y < eff_h; y++)
        for (int x = 0; x < eff_w; x++)
          for (int c = 0; c < eff_c; c++) begin
            b = '{OP_WRITE, x, y, c, 16'($urandom), 1'b0, 1'b0, 16'h0};
            b.fe = (y == eff_h - 1 && x == eff_w - 1 && c == eff_c - 1);
            push_beat(b);
          end
  endtask

  task automatic random_beats(int count);
    beat_t b;
    for (int i = 0; i < count; i++) begin
      b = '{OP_QUERY, 0, 0, 0, 16'($urandom), 1'b0, 1'b0, 16'h0};
      if ($urandom_range(0, 99) < 70) begin
        b.op = OP_QUERY;
        if ($urandom_range(0, 1) == 0) begin
          b.x = $urandom_range(0, 127);
          b.y = $urandom_range(0, 127);
          b.c = $urandom_range(0, 3);
        end else begin
          b.x = $urandom_range(0, eff_w - 1);
          b.y = $urandom_range(0, eff_h - 1);
          b.c = $urandom_range(0, eff_c - 1);
        end
        b.fe = $urandom_range(0, 1);
      end else begin
        b.op = OP_WRITE;
        if ($urandom_range(0, 6) == 0) begin
          b.x = $urandom_range(0, 127);
          b.y = $urandom_range(0, 127);
          b.c = $urandom_range(0, 3);
        end else begin
          b.x = $urandom_range(0, eff_w - 1);
          b.y = $urandom_range(0, eff_h - 1);
          b.c = $urandom_range(0, eff_c - 1);
        end
        b.fe = ($urandom_range(0, 9) == 0);
      end
      push_beat(b);
    end
  endtask

  // result side
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (median_q.size() == 0) begin
          report_mismatch("unexpected beat", out_median, 16'h0);
        end else begin
          if (out_median !== median_q[0])
            report_mismatch("median", out_median, median_q[0]);
          void'(median_q.pop_front());
        end
        n_results++;
      end
      if (!held_off && n_results >= 150) begin
        held_off = 1'b1;
        out_pop <= 1'b0;
        repeat (600) @(posedge clk);
      end
      if (calm) begin
        out_pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    beat_t steps[$];
    eff_w = 128; eff_h = 128; eff_c = 1;
    win_x = 3; win_y = 3; win_z = 3; cmp_sgn = 1'b0; ring_slot = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two pixel frame, single point window
    set_regs(2, 1, 1, 1, 1, 1, 0);
    steps = '{
      '{OP_WRITE, 0, 0, 0, 16'hFFFF, 1'b0, 1'b0, 16'h0},
      '{OP_WRITE, 1, 0, 0, 16'h0000, 1'b0, 1'b0, 16'h0},
      '{OP_QUERY, 0, 0, 0, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
      '{OP_QUERY, 1, 0, 0, 16'hFFFF, 1'b1, 1'b1, 16'h0000},
      '{OP_QUERY, 127, 127, 3, 16'h5555, 1'b0, 1'b1, 16'h0000},
      '{OP_WRITE, 127, 127, 3, 16'h1234, 1'b1, 1'b0, 16'h0},
      '{OP_QUERY, 0, 0, 0, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
      '{OP_WRITE, 0, 0, 0, 16'h8000, 1'b1, 1'b0, 16'h0},
      '{OP_QUERY, 0, 0, 0, 16'h0000, 1'b0, 1'b1, 16'h8000},
      '{OP_WRITE, 1, 0, 0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
      '{OP_QUERY, 5, 0, 1, 16'h0000, 1'b0, 1'b1, 16'h7FFF}
    };
    foreach (steps[i]) push_beat(steps[i]);
    wait_idle();

    // extremes of the dimension and window registers
    set_regs(255, 1, 1, 5, 1, 1, 0);
    fill_ring(); random_beats(60); wait_idle();
    set_regs(1, 128, 1, 1, 5, 1, 1);
    fill_ring(); random_beats(60); wait_idle();
    set_regs(0, 0, 0, 0, 0, 0, 0);
    fill_ring(); random_beats(40); wait_idle();
    set_regs(4, 3, 7, 5, 5, 5, 1);
    fill_ring(); random_beats(80); wait_idle();
    set_regs(5, 4, 2, 4, 6, 7, 0);
    fill_ring(); random_beats(80); wait_idle();

    for (int p = 0; p < 5; p++) begin
      set_regs($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 7),
               $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, 1));
      if (p == 4) calm = 1'b1;
      fill_ring(); random_beats(30); wait_idle();
    end

    repeat (200) @(posedge clk);
    if (errs == 0 && median_q.size() == 0) begin
      $display("spatiotemporal_median_filter_core: match");
    end else begin
      $display("spatiotemporal_median_filter_core: mismatch");
    end
    $finish;
  end

endmodule
